/* hw/rtl/psat_pkg.sv */
package psat_pkg;

   localparam int unsigned SEQ_BITS    = 9;
   localparam int unsigned CNT_BITS    = 32;
   localparam int unsigned RECV_WINDOW = 32;
   localparam int unsigned MASK_BITS   = 32;

   localparam logic [CNT_BITS-1:0] SEQ_SPAN    = CNT_BITS'(1 << SEQ_BITS);
   localparam logic [CNT_BITS-1:0] WINDOW_LAST = CNT_BITS'(RECV_WINDOW - 1);
   localparam logic [2:0]          MAX_ACK_BYTES = 3'd4;

   typedef enum logic {
      OP_RECEIVE = 1'b0,
      OP_SEND    = 1'b1
   } psat_op_type;

   typedef enum logic [1:0] {
      PKT_DATA    = 2'd0,
      PKT_PING    = 2'd1,
      PKT_ACK     = 2'd2,
      PKT_INVALID = 2'd3
   } psat_pkt_type;

   typedef struct packed {
      psat_op_type          operation;
      logic                 parity_bit;
      logic [SEQ_BITS-1:0]  seq_low;
      logic [SEQ_BITS-1:0]  ack_low;
      psat_pkt_type         packet_type;
      logic [2:0]           ack_bytes;
      logic [MASK_BITS-1:0] ack_bits_in;
   } psat_req_type;

   typedef struct packed {
      psat_op_type          result_kind;
      logic                 accepted;
      logic                 dispatch_data;
      logic [CNT_BITS-1:0]  first_acked;
      logic [SEQ_BITS-1:0]  acked_count;
      logic [MASK_BITS-1:0] acked_hits;
      logic                 established;
      logic [SEQ_BITS-1:0]  out_sequence;
      logic [SEQ_BITS-1:0]  out_highest_ack;
      logic [2:0]           out_ack_bytes;
      logic [MASK_BITS-1:0] out_ack_mask;
   } psat_rsp_type;

   function automatic logic [2:0] mask_byte_count(input logic [MASK_BITS-1:0] m);
      logic [2:0] n;
      n = 3'd0;
      if (m[31:24] != 8'd0) begin
         n = 3'd4;
      end else if (m[23:16] != 8'd0) begin
         n = 3'd3;
      end else if (m[15:8] != 8'd0) begin
         n = 3'd2;
      end else if (m[7:0] != 8'd0) begin
         n = 3'd1;
      end
      return n;
   endfunction

   function automatic logic [MASK_BITS-1:0] byte_mask(input logic [2:0] nbytes);
      logic [MASK_BITS-1:0] m;
      unique case (nbytes)
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         3'd4:    m = 32'hffff_ffff;
         default: m = 32'h0000_0000;
      endcase
      return m;
   endfunction

endpackage

/* hw/rtl/packet_sequence_ack_tracker.sv */
// Sequence and ack tracker for one side of a datagram link with 9-bit wire
// numbers. Each req beat is either a received header (tuser 0), checked and
// folded into the 32-bit sequence/ack state, or a send request (tuser 1),
// answered with the header fields to put on the wire. Every req beat yields
// exactly one rsp beat, registered in the input register and then the result
// register; a new beat is taken every cycle while rsp_tready is held high, since
// the state is read and updated between the two registers. csr_we loads the
// connect parity bit, and should be used only while no beat is in flight.
module packet_sequence_ack_tracker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_wdata,      // connect_parity
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,      // parity_bit, seq_low, ack_low, packet_type,
                                        // ack_bytes, ack_bits_in
   input  logic         req_tuser,      // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,      // accepted, dispatch_data, first_acked,
                                        // acked_count, acked_hits, established,
                                        // out_sequence, out_highest_ack,
                                        // out_ack_bytes, out_ack_mask, zero fill
   output logic         rsp_tuser       // result_kind
);
   import psat_pkg::*;

   psat_req_type req_in, req_ff;
   logic         req_valid_ff;
   psat_rsp_type rsp_in, rsp_ff;
   logic         rsp_valid_ff;
   logic         advance, step;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = req_valid_ff && advance;
   assign req_tready = !req_valid_ff || advance;

   assign req_in.operation   = psat_op_type'(req_tuser);
   assign req_in.parity_bit  = req_tdata[0];
   assign req_in.seq_low     = req_tdata[9:1];
   assign req_in.ack_low     = req_tdata[18:10];
   assign req_in.packet_type = psat_pkt_type'(req_tdata[20:19]);
   assign req_in.ack_bytes   = req_tdata[23:21];
   assign req_in.ack_bits_in = req_tdata[55:24];

   psat_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step      (step),
      .req       (req_ff),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff <= req_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.result_kind;
   assign rsp_tdata  = {7'd0,
                        rsp_ff.out_ack_mask,
                        rsp_ff.out_ack_bytes,
                        rsp_ff.out_highest_ack,
                        rsp_ff.out_sequence,
                        rsp_ff.established,
                        rsp_ff.acked_hits,
                        rsp_ff.acked_count,
                        rsp_ff.first_acked,
                        rsp_ff.dispatch_data,
                        rsp_ff.accepted};

endmodule

/* hw/rtl/psat_tracker.sv */
module psat_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic                 step,
   input  psat_pkg::psat_req_type req,
   output psat_pkg::psat_rsp_type rsp
);
   import psat_pkg::*;

   logic                 parity_ff;
   logic [CNT_BITS-1:0]  last_rx_ff, last_rx_in;
   logic [CNT_BITS-1:0]  high_ack_ff, high_ack_in;
   logic [CNT_BITS-1:0]  last_tx_ff, last_tx_in;
   logic [MASK_BITS-1:0] rx_bits_ff, rx_bits_in;
   logic                 link_up_ff, link_up_in;

   logic [CNT_BITS-1:0]  seq_base, seq_ext, seq_diff, window_end;
   logic [CNT_BITS-1:0]  ack_base, ack_ext, ack_diff;
   logic [SEQ_BITS-1:0]  count;
   logic [MASK_BITS-1:0] bits, lim_mask, hits;
   logic                 hdr_ok, rx_ok, is_data;

   assign is_data    = (req.packet_type == PKT_DATA);
   assign hdr_ok     = (req.parity_bit == parity_ff) && (req.ack_bytes <= MAX_ACK_BYTES)
                       && (req.packet_type != PKT_INVALID);
   assign bits       = req.ack_bits_in & byte_mask(req.ack_bytes);

   assign seq_base   = {last_rx_ff[CNT_BITS-1:SEQ_BITS], req.seq_low};
   assign seq_ext    = (seq_base < last_rx_ff) ? seq_base + SEQ_SPAN : seq_base;
   assign window_end = last_rx_ff + WINDOW_LAST;
   assign seq_diff   = seq_ext - last_rx_ff;

   assign ack_base   = {high_ack_ff[CNT_BITS-1:SEQ_BITS], req.ack_low};
   assign ack_ext    = (ack_base < high_ack_ff) ? ack_base + SEQ_SPAN : ack_base;
   assign ack_diff   = ack_ext - high_ack_ff;
   assign count      = ack_diff[SEQ_BITS-1:0];

   assign lim_mask   = (count >= SEQ_BITS'(RECV_WINDOW)) ? '1
                       : (MASK_BITS'(1) << count[4:0]) - MASK_BITS'(1);
   assign hits       = bits & lim_mask;

   assign rx_ok      = hdr_ok && !(seq_ext > window_end) && !(ack_ext > last_tx_ff);

   always_comb begin
      rsp         = '0;
      last_rx_in  = last_rx_ff;
      high_ack_in = high_ack_ff;
      last_tx_in  = last_tx_ff;
      rx_bits_in  = rx_bits_ff;
      link_up_in  = link_up_ff;
      rsp.result_kind = req.operation;
      unique case (req.operation)
         OP_SEND: begin
            if (is_data) begin
               last_tx_in = last_tx_ff + CNT_BITS'(1);
            end
            rsp.out_sequence    = last_tx_in[SEQ_BITS-1:0];
            rsp.out_highest_ack = last_rx_ff[SEQ_BITS-1:0];
            rsp.out_ack_bytes   = mask_byte_count(rx_bits_ff);
            rsp.out_ack_mask    = rx_bits_ff;
         end
         default: begin
            if (rx_ok) begin
               rsp.accepted      = 1'b1;
               rsp.dispatch_data = is_data && (seq_ext != last_rx_ff);
               rx_bits_in        = (rx_bits_ff << seq_diff[4:0]) | MASK_BITS'(is_data);
               if (count != '0) begin
                  rsp.first_acked = high_ack_ff + CNT_BITS'(1);
                  rsp.acked_count = count;
                  rsp.acked_hits  = hits;
                  if (hits != '0) begin
                     link_up_in = 1'b1;
                  end
               end
               high_ack_in = ack_ext;
               last_rx_in  = seq_ext;
            end
         end
      endcase
      rsp.established = link_up_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff   <= 1'b0;
         last_rx_ff  <= '0;
         high_ack_ff <= '0;
         last_tx_ff  <= '0;
         rx_bits_ff  <= '0;
         link_up_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            parity_ff <= csr_wdata;
         end
         if (step) begin
            last_rx_ff  <= last_rx_in;
            high_ack_ff <= high_ack_in;
            last_tx_ff  <= last_tx_in;
            rx_bits_ff  <= rx_bits_in;
            link_up_ff  <= link_up_in;
         end
      end
   end

endmodule
